[rtl/crso_pkg.sv]
// ----------------------------------------------------------------------------
// crso_pkg
// Shared constants, types and arithmetic helpers for the source-over rect fill.
// ----------------------------------------------------------------------------
package crso_pkg;

  localparam int COORD_BITS = 12;

  // input word: pixel_x, pixel_y, dst_pixel from the lowest bit up, byte padded
  localparam int IN_FIELDS_W = 2 * COORD_BITS + 32;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

  // signed compare width, holds any 16-bit edge and any coordinate
  localparam int CMP_W = 17;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_RECT_LEFT     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_RECT_TOP      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RECT_RIGHT    = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RECT_BOTTOM   = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BITMAP_WIDTH  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BITMAP_HEIGHT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_SOURCE_COLOR  = 3'd6;

  localparam logic [12:0] BITMAP_SIZE_RST = 13'd4096;

  // per-stage load strobes and the write flag seen by the last stage
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic we2;
  } stage_ctl_t;

  // round(p/255) for p a product of two bytes
  function automatic logic [7:0] div255r(input logic [15:0] p);
    logic [16:0] t;
    logic [16:0] s;
    t = {1'b0, p} + 17'd128;
    s = t + {8'd0, t[16:8]};
    return s[15:8];
  endfunction

endpackage

[rtl/clipped_rect_src_over_blend.sv]
// ----------------------------------------------------------------------------
// clipped_rect_src_over_blend
// Per-pixel source-over blend of a constant colour inside a clipped rectangle.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while in_tready is high and returns one
// result word per pixel, in order, through three register stages: clip test
// and the 8x8 channel products, the divide by 255 with rounding, and the
// saturating add with the pass-through select. Each stage holds its word
// until the next one frees up, so bubbles are squeezed out and in_tready
// drops only when all three stages are full and out_tready is low. The user
// must write registers on the cfg port only while no pixel is in flight; the
// block itself does not enforce this. out_tuser is set when the pixel was
// written, otherwise out_tdata returns the destination unchanged.
module clipped_rect_src_over_blend (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [crso_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [crso_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // pixel_x, pixel_y, dst_pixel
  input  logic [crso_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // new_pixel
  output logic [31:0]                       out_tdata,
  // write_enable
  output logic [0:0]                        out_tuser
);

  localparam int CB = crso_pkg::COORD_BITS;
  localparam int CW = crso_pkg::CMP_W;

  // configuration registers
  logic signed [15:0] rect_left_r;
  logic signed [15:0] rect_top_r;
  logic signed [15:0] rect_right_r;
  logic signed [15:0] rect_bottom_r;
  logic [12:0]        bitmap_width_r;
  logic [12:0]        bitmap_height_r;
  logic [31:0]        source_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rect_left_r     <= '0;
      rect_top_r      <= '0;
      rect_right_r    <= '0;
      rect_bottom_r   <= '0;
      bitmap_width_r  <= crso_pkg::BITMAP_SIZE_RST;
      bitmap_height_r <= crso_pkg::BITMAP_SIZE_RST;
      source_color_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        crso_pkg::REG_RECT_LEFT:     rect_left_r     <= cfg_wdata[15:0];
        crso_pkg::REG_RECT_TOP:      rect_top_r      <= cfg_wdata[15:0];
        crso_pkg::REG_RECT_RIGHT:    rect_right_r    <= cfg_wdata[15:0];
        crso_pkg::REG_RECT_BOTTOM:   rect_bottom_r   <= cfg_wdata[15:0];
        crso_pkg::REG_BITMAP_WIDTH:  bitmap_width_r  <= cfg_wdata[12:0];
        crso_pkg::REG_BITMAP_HEIGHT: bitmap_height_r <= cfg_wdata[12:0];
        crso_pkg::REG_SOURCE_COLOR:  source_color_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // pipeline handshake
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  crso_pkg::stage_ctl_t ctl;

  assign rdy3 = !v3_r || out_tready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  assign in_tready  = rdy1;
  assign out_tvalid = v3_r;

  // input word fields
  logic [CB-1:0] pixel_x;
  logic [CB-1:0] pixel_y;
  logic [31:0]   dst_pixel;

  assign pixel_x   = in_tdata[CB-1:0];
  assign pixel_y   = in_tdata[2*CB-1:CB];
  assign dst_pixel = in_tdata[2*CB+31:2*CB];

  // clip test; coordinates are never negative, so only the upper limits need a min
  logic signed [CW-1:0] x_s, y_s;
  logic                 in_x, in_y;
  logic [7:0]           src_a, src_inv;
  logic                 we1_nxt;

  assign x_s = signed'({{(CW-CB){1'b0}}, pixel_x});
  assign y_s = signed'({{(CW-CB){1'b0}}, pixel_y});

  assign in_x = (x_s >= CW'(rect_left_r)) && (x_s < CW'(rect_right_r))
             && (x_s < signed'({{(CW-13){1'b0}}, bitmap_width_r}));
  assign in_y = (y_s >= CW'(rect_top_r)) && (y_s < CW'(rect_bottom_r))
             && (y_s < signed'({{(CW-13){1'b0}}, bitmap_height_r}));

  assign src_a   = source_color_r[31:24];
  assign src_inv = 8'hFF - src_a;
  assign we1_nxt = (src_a != 8'd0) && in_x && in_y;

  logic we1_r, we2_r, we3_r;

  assign ctl.en1 = in_tvalid && rdy1;
  assign ctl.en2 = v1_r && rdy2;
  assign ctl.en3 = v2_r && rdy3;
  assign ctl.we2 = we2_r;

  always_ff @(posedge clk) begin
    if (ctl.en1) we1_r <= we1_nxt;
    if (ctl.en2) we2_r <= we1_r;
    if (ctl.en3) we3_r <= we2_r;
  end

  // alpha blends like a colour channel whose source value is full scale
  logic [7:0] res_a, res_r, res_g, res_b;

  crso_chan u_chan_a (
    .clk     (clk),
    .ctl     (ctl),
    .src_a   (src_a),
    .src_inv (src_inv),
    .src_c   (8'hFF),
    .dst_c   (dst_pixel[31:24]),
    .res     (res_a)
  );

  crso_chan u_chan_r (
    .clk     (clk),
    .ctl     (ctl),
    .src_a   (src_a),
    .src_inv (src_inv),
    .src_c   (source_color_r[23:16]),
    .dst_c   (dst_pixel[23:16]),
    .res     (res_r)
  );

  crso_chan u_chan_g (
    .clk     (clk),
    .ctl     (ctl),
    .src_a   (src_a),
    .src_inv (src_inv),
    .src_c   (source_color_r[15:8]),
    .dst_c   (dst_pixel[15:8]),
    .res     (res_g)
  );

  crso_chan u_chan_b (
    .clk     (clk),
    .ctl     (ctl),
    .src_a   (src_a),
    .src_inv (src_inv),
    .src_c   (source_color_r[7:0]),
    .dst_c   (dst_pixel[7:0]),
    .res     (res_b)
  );

  assign out_tdata = {res_a, res_r, res_g, res_b};
  assign out_tuser = we3_r;

  // back-pressure only when every stage is occupied
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (v1_r && v2_r && v3_r))
    else $error("input stalled with a free pipeline stage");

  // a word in stage one that may advance shows up in stage two
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && rdy2) |=> v2_r)
    else $error("word lost between stage one and stage two");

  // a written pixel carries at least the nonzero source alpha
  a_alpha_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[31:24] != 8'd0))
    else $error("written pixel with zero alpha");

endmodule

[rtl/crso_chan.sv]
// ----------------------------------------------------------------------------
// crso_chan
// One channel: multiply, divide by 255, add and saturate, or pass dst through.
// ----------------------------------------------------------------------------
module crso_chan (
  input  logic                 clk,
  input  crso_pkg::stage_ctl_t ctl,
  input  logic [7:0]           src_a,
  input  logic [7:0]           src_inv,
  input  logic [7:0]           src_c,
  input  logic [7:0]           dst_c,
  output logic [7:0]           res
);

  logic [15:0] p_src_r;
  logic [15:0] p_dst_r;
  logic [7:0]  d1_r;
  logic [7:0]  q_src_r;
  logic [7:0]  q_dst_r;
  logic [7:0]  d2_r;
  logic [7:0]  res_r;
  logic [8:0]  sum;
  logic [7:0]  res_nxt;

  always_ff @(posedge clk) begin
    if (ctl.en1) begin
      p_src_r <= src_a * src_c;
      p_dst_r <= src_inv * dst_c;
      d1_r    <= dst_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en2) begin
      q_src_r <= crso_pkg::div255r(p_src_r);
      q_dst_r <= crso_pkg::div255r(p_dst_r);
      d2_r    <= d1_r;
    end
  end

  assign sum = {1'b0, q_src_r} + {1'b0, q_dst_r};

  always_comb begin
    if (!ctl.we2) begin
      res_nxt = d2_r;
    end else if (sum[8]) begin
      res_nxt = 8'hFF;
    end else begin
      res_nxt = sum[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en3) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

[tb/sv/clipped_rect_src_over_blend_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rect_src_over_blend_checker
// Watches the cfg port and both stream channels. Keeps its own copy of the
// registers, works out the blended pixel for every accepted pixel word and
// compares each result word with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module clipped_rect_src_over_blend_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [crso_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [crso_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // pixel_x, pixel_y, dst_pixel
  input  logic [crso_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // new_pixel
  input  logic [31:0]                     out_tdata,
  // write_enable
  input  logic [0:0]                      out_tuser,
  output int                              mismatches,
  output int                              outstanding
);

  localparam int CB = crso_pkg::COORD_BITS;

  typedef struct packed {
    logic        written;
    logic [31:0] pixel;
  } blend_t;

  blend_t blend_q[$];
  blend_t due;
  int     err_count = 0;

  logic signed [15:0] rect_left, rect_top, rect_right, rect_bottom;
  logic [12:0]        bmp_w, bmp_h;
  logic [31:0]        src_color;

  function automatic logic [7:0] round_div255(int p);
    return 8'((p + 127) / 255);
  endfunction

  function automatic blend_t blend_pixel(logic [CB-1:0] px,
                                         logic [CB-1:0] py,
                                         logic [31:0]   dst);
    int     lo_x, hi_x, lo_y, hi_y;
    int     alpha, inv, sum, sh;
    blend_t r;
    // rectangle clipped to the bitmap
    lo_x = (rect_left < 0) ? 0 : int'(rect_left);
    lo_y = (rect_top < 0) ? 0 : int'(rect_top);
    hi_x = (int'(rect_right) > int'(bmp_w)) ? int'(bmp_w) : int'(rect_right);
    hi_y = (int'(rect_bottom) > int'(bmp_h)) ? int'(bmp_h) : int'(rect_bottom);
    alpha = int'(src_color[31:24]);
    r.written = (alpha != 0) && (int'(px) >= lo_x) && (int'(px) < hi_x)
                && (int'(py) >= lo_y) && (int'(py) < hi_y);
    r.pixel = dst;
    if (r.written) begin
      inv = 255 - alpha;
      sum = alpha + int'(round_div255(inv * int'(dst[31:24])));
      r.pixel[31:24] = (sum > 255) ? 8'd255 : sum[7:0];
      for (sh = 0; sh < 24; sh += 8) begin
        sum = int'(round_div255(alpha * int'(src_color[sh +: 8])))
              + int'(round_div255(inv * int'(dst[sh +: 8])));
        r.pixel[sh +: 8] = (sum > 255) ? 8'd255 : sum[7:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rect_left   = '0;
      rect_top    = '0;
      rect_right  = '0;
      rect_bottom = '0;
      bmp_w       = crso_pkg::BITMAP_SIZE_RST;
      bmp_h       = crso_pkg::BITMAP_SIZE_RST;
      src_color   = '0;
      blend_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          crso_pkg::REG_RECT_LEFT: begin
            rect_left = cfg_wdata[15:0];
          end
          crso_pkg::REG_RECT_TOP: begin
            rect_top = cfg_wdata[15:0];
          end
          crso_pkg::REG_RECT_RIGHT: begin
            rect_right = cfg_wdata[15:0];
          end
          crso_pkg::REG_RECT_BOTTOM: begin
            rect_bottom = cfg_wdata[15:0];
          end
          crso_pkg::REG_BITMAP_WIDTH: begin
            bmp_w = cfg_wdata[12:0];
          end
          crso_pkg::REG_BITMAP_HEIGHT: begin
            bmp_h = cfg_wdata[12:0];
          end
          crso_pkg::REG_SOURCE_COLOR: begin
            src_color = cfg_wdata[31:0];
          end
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        blend_q.push_back(blend_pixel(in_tdata[CB-1:0],
                                      in_tdata[2*CB-1:CB],
                                      in_tdata[2*CB +: 32]));
      end
      if (out_tvalid && out_tready) begin
        if (blend_q.size() == 0) begin
          $error("unexpected result word: new_pixel %h write_enable %b",
                 out_tdata, out_tuser);
          err_count++;
        end else begin
          due = blend_q.pop_front();
          if (out_tuser[0] !== due.written) begin
            $error("write_enable: expected %b, actual %b", due.written, out_tuser[0]);
            err_count++;
          end
          if (out_tdata !== due.pixel) begin
            $error("new_pixel: expected %h, actual %h", due.pixel, out_tdata);
            err_count++;
          end
        end
      end
    end
    mismatches  <= err_count;
    outstanding <= blend_q.size();
  end

endmodule

[tb/sv/clipped_rect_src_over_blend_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clipped_rect_src_over_blend_tb
// Drives pixel words and register settings into the rect fill blend stage,
// with random gaps and back-pressure, and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module clipped_rect_src_over_blend_tb;

  localparam int CB           = crso_pkg::COORD_BITS;
  localparam int AW           = crso_pkg::CFG_ADDR_W;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1550;
  localparam int DRAIN_CYCLES = 8;
  localparam int COORD_MAX    = (1 << CB) - 1;
  localparam logic [AW-1:0] REG_SPARE = 3'd7;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [AW-1:0]                       cfg_addr = '0;
  logic [crso_pkg::CFG_DATA_W-1:0]     cfg_wdata = '0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [crso_pkg::IN_DATA_W-1:0]      in_tdata = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [31:0]                         out_tdata;
  logic [0:0]                          out_tuser;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int sent = 0;
  int n_pix;
  int win_x0, win_x1, win_y0, win_y1;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  clipped_rect_src_over_blend uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  clipped_rect_src_over_blend_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("clipped_rect_src_over_blend verification failed");
      $finish;
    end
  end

  // result side: random stall before each word, none in burst phases
  initial begin
    int stall;
    @(posedge rst_n);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 16);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic write_reg(logic [AW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
  endtask

  task automatic close_cfg();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int l, int t, int r, int b, int w, int h, logic [31:0] color);
    write_reg(crso_pkg::REG_RECT_LEFT, 32'(16'(l)));
    write_reg(crso_pkg::REG_RECT_TOP, 32'(16'(t)));
    write_reg(crso_pkg::REG_RECT_RIGHT, 32'(16'(r)));
    write_reg(crso_pkg::REG_RECT_BOTTOM, 32'(16'(b)));
    write_reg(crso_pkg::REG_BITMAP_WIDTH, 32'(13'(w)));
    write_reg(crso_pkg::REG_BITMAP_HEIGHT, 32'(13'(h)));
    write_reg(crso_pkg::REG_SOURCE_COLOR, color);
    close_cfg();
  endtask

  // stop sending and wait until every pixel has come back
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_pixel(int x, int y, logic [31:0] dst);
    int                             gap;
    logic [crso_pkg::IN_DATA_W-1:0] word;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    word = '0;
    word[CB-1:0] = CB'(x);
    word[2*CB-1:CB] = CB'(y);
    word[2*CB +: 32] = dst;
    repeat (gap) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
  endtask

  // mostly near the clipped window, so both edges get hit
  function automatic int pick_coord(int lo, int hi);
    int a, b;
    if ($urandom_range(0, 4) == 0) return $urandom_range(0, COORD_MAX);
    a = (lo - 3 < 0) ? 0 : lo - 3;
    b = (hi + 3 > COORD_MAX) ? COORD_MAX : hi + 3;
    if (a > b) return $urandom_range(0, COORD_MAX);
    return $urandom_range(a, b);
  endfunction

  task automatic random_setting();
    int          l, t, r, b, w, h;
    logic [31:0] color;
    if ($urandom_range(0, 7) == 0) begin
      l = int'($urandom_range(0, 65535)) - 32768;
      t = int'($urandom_range(0, 65535)) - 32768;
      r = int'($urandom_range(0, 65535)) - 32768;
      b = int'($urandom_range(0, 65535)) - 32768;
    end else begin
      l = int'($urandom_range(0, 4300)) - 150;
      t = int'($urandom_range(0, 4300)) - 150;
      r = l + int'($urandom_range(0, 700)) - 30;
      b = t + int'($urandom_range(0, 700)) - 30;
    end
    case ($urandom_range(0, 19))
      0: w = 0;
      1, 2: w = $urandom_range(4097, 8191);
      default: w = $urandom_range(1, 4096);
    endcase
    case ($urandom_range(0, 19))
      0: h = 0;
      1, 2: h = $urandom_range(4097, 8191);
      default: h = $urandom_range(1, 4096);
    endcase
    color = $urandom();
    case ($urandom_range(0, 11))
      0: color[31:24] = 8'h00;
      1, 2: color[31:24] = 8'hFF;
      default: begin
      end
    endcase
    // unused upper bits of the write data carry noise
    write_reg(crso_pkg::REG_RECT_LEFT, {16'($urandom()), 16'(l)});
    write_reg(crso_pkg::REG_RECT_TOP, {16'($urandom()), 16'(t)});
    write_reg(crso_pkg::REG_RECT_RIGHT, {16'($urandom()), 16'(r)});
    write_reg(crso_pkg::REG_RECT_BOTTOM, {16'($urandom()), 16'(b)});
    write_reg(crso_pkg::REG_BITMAP_WIDTH, {19'($urandom()), 13'(w)});
    write_reg(crso_pkg::REG_BITMAP_HEIGHT, {19'($urandom()), 13'(h)});
    write_reg(crso_pkg::REG_SOURCE_COLOR, color);
    if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom());
    close_cfg();
    win_x0 = l;
    win_y0 = t;
    win_x1 = (r > w) ? w : r;
    win_y1 = (b > h) ? h : b;
  endtask

  initial begin
    logic [31:0] dst;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // registers as left by reset: empty rect, zero alpha
    send_pixel(0, 0, 32'h12345678);
    send_pixel(COORD_MAX, COORD_MAX, 32'hFFFFFFFF);

    // rectangle edges, inclusive and exclusive
    drain();
    set_regs(10, 20, 100, 200, 4096, 4096, 32'h80C04020);
    send_pixel(10, 20, 32'h00000000);
    send_pixel(9, 20, 32'h40302010);
    send_pixel(99, 199, 32'hFFFFFFFF);
    send_pixel(100, 199, 32'hFFFFFFFF);
    send_pixel(99, 200, 32'h7F7F7F7F);
    send_pixel(10, 19, 32'h7F7F7F7F);

    // widest rectangle, oversized bitmap, opaque source
    drain();
    set_regs(-32768, -32768, 32767, 32767, 8191, 8191, 32'hFFFFFFFF);
    send_pixel(0, 0, 32'h00000000);
    send_pixel(COORD_MAX, COORD_MAX, 32'hFFFFFFFF);
    send_pixel(COORD_MAX, 0, 32'hA5A5A5A5);

    // colour components above alpha
    drain();
    write_reg(crso_pkg::REG_SOURCE_COLOR, 32'h01FF00FF);
    close_cfg();
    send_pixel(2048, 1024, 32'hFFFFFFFF);
    send_pixel(1, COORD_MAX - 1, 32'h00000000);

    // zero bitmap width, then zero height
    drain();
    write_reg(crso_pkg::REG_BITMAP_WIDTH, 32'd0);
    close_cfg();
    send_pixel(0, 0, 32'h11223344);
    drain();
    write_reg(crso_pkg::REG_BITMAP_WIDTH, 32'd4096);
    write_reg(crso_pkg::REG_BITMAP_HEIGHT, 32'd0);
    close_cfg();
    send_pixel(0, 0, 32'h11223344);

    // inverted rectangle, then an empty one
    drain();
    set_regs(200, 0, 100, 4096, 4096, 4096, 32'hC0808080);
    send_pixel(150, 10, 32'h55555555);
    send_pixel(100, 10, 32'h55555555);
    send_pixel(200, 10, 32'h55555555);
    drain();
    set_regs(50, 50, 50, 50, 4096, 4096, 32'hC0808080);
    send_pixel(50, 50, 32'h55555555);

    // zero source alpha, and writes to the unused index
    drain();
    set_regs(0, 0, 4096, 4096, 4096, 4096, 32'h00FFFFFF);
    write_reg(REG_SPARE, 32'hFFFFFFFF);
    close_cfg();
    send_pixel(5, 5, 32'h80808080);
    drain();
    write_reg(crso_pkg::REG_SOURCE_COLOR, 32'hFF000000);
    write_reg(REG_SPARE, 32'h00000000);
    close_cfg();
    send_pixel(5, 5, 32'h80808080);

    while (sent < RANDOM_ITEMS) begin
      drain();
      random_setting();
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      n_pix = $urandom_range(20, 80);
      repeat (n_pix) begin
        case ($urandom_range(0, 15))
          0: dst = 32'h00000000;
          1: dst = 32'hFFFFFFFF;
          default: dst = $urandom();
        endcase
        send_pixel(pick_coord(win_x0, win_x1), pick_coord(win_y0, win_y1), dst);
        sent++;
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("clipped_rect_src_over_blend verification clean");
    end else begin
      $display("clipped_rect_src_over_blend verification failed");
    end
    $finish;
  end

endmodule

[clipped_rect_src_over_blend.f]
rtl/crso_pkg.sv
rtl/crso_chan.sv
rtl/clipped_rect_src_over_blend.sv
tb/sv/clipped_rect_src_over_blend_checker.sv
tb/sv/clipped_rect_src_over_blend_tb.sv
